// ===== rtl/bmp_stream_pixel_decoder_unit_macros.svh =====
// ---------------------------------------------------------------------------
// bmp_stream_pixel_decoder_unit_macros
// Assertion macros used by the decoder RTL.
// ---------------------------------------------------------------------------
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef BMP_STREAM_PIXEL_DECODER_UNIT_MACROS_SVH
`define BMP_STREAM_PIXEL_DECODER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMPD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decoder assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BMPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decoder assertion failed");

`endif

// ===== rtl/bmpd_pkg.sv =====
// ---------------------------------------------------------------------------
// bmpd_pkg
// Types and constants shared by the BMP stream pixel decoder modules.
// ---------------------------------------------------------------------------
package bmpd_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int DIM_W      = 13;
  localparam int PAL_DEPTH  = 256;
  localparam int PAL_AW     = 8;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;
  localparam int CFG_AW     = 3;

  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;
  localparam logic [31:0] INFO_MIN = 32'd40;
  localparam logic [31:0] INFO_BAD = 32'd64;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CORRUPT = 2'd1;
  localparam logic [1:0] ST_UNSUP   = 2'd2;
  localparam logic [1:0] ST_NONGRAY = 2'd3;

  localparam logic REG_MONO_OUTPUT = 1'b0;

  typedef enum logic [2:0] {
    PH_SIG, PH_FHDR, PH_INFO, PH_PAL, PH_PIX, PH_DONE, PH_ERR
  } phase_t;

  typedef struct packed {
    logic       pixel_valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] status;
    logic       last_in_run;
    logic       end_of_image;
  } result_t;

endpackage

// ===== rtl/bmpd_pal_ram.sv =====
// ---------------------------------------------------------------------------
// bmpd_pal_ram
// Palette store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module bmpd_pal_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [bmpd_pkg::PAL_AW-1:0] wr_addr,
  input  logic [23:0]                wr_data,
  input  logic                       rd_en,
  input  logic [bmpd_pkg::PAL_AW-1:0] rd_addr,
  output logic [23:0]                rd_data
);
  import bmpd_pkg::*;

  logic [23:0] mem [PAL_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/bmpd_out_fifo.sv =====
// ---------------------------------------------------------------------------
// bmpd_out_fifo
// Small result queue that decouples the decoder from the result receiver.
// ---------------------------------------------------------------------------
module bmpd_out_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  bmpd_pkg::result_t            push_data,
  input  logic                         pop,
  output bmpd_pkg::result_t            head,
  output logic                         not_empty,
  output logic [bmpd_pkg::FIFO_CW-1:0] count
);
  import bmpd_pkg::*;

  result_t              entry_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      cnt_r <= cnt_r + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

  assign head      = entry_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;

endmodule

// ===== rtl/bmp_stream_pixel_decoder_unit.sv =====
// ---------------------------------------------------------------------------
// bmp_stream_pixel_decoder_unit
// Parses an uncompressed BMP byte stream and produces one RGB pixel per
// result transfer, with status results for corrupted or unsupported files.
// ---------------------------------------------------------------------------
// Usage. The input channel (in_valid, in_stall, in_data_byte,
// in_start_of_file) carries one file byte per transfer; in_start_of_file marks
// byte zero of a new file and restarts parsing. The result channel (out_valid,
// out_stall, out_*) carries pixels and status results in file order. The APB
// port holds one register, mono_output, at byte address 0.
// A byte is held until every result it causes has been issued, so header and
// 8 or 24 bit pixel bytes move at one per cycle while the result queue has
// room, and a 1 bit per pixel byte is held for up to eight results: the
// palette read port gives one lookup per cycle. The first result of a byte
// passes from the hold register through the palette read stage into the
// result queue and then sits at its head. Reset clears the parse state and
// mono_output; the palette memory is not cleared and needs no clearing
// pass. When the receiver stalls, the four entry result queue fills and
// then the byte stage waits, so input transfers stop until space returns.
// Nothing is dropped.
// ---------------------------------------------------------------------------
`include "bmp_stream_pixel_decoder_unit_macros.svh"

module bmp_stream_pixel_decoder_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_data_byte,
  input  logic                         in_start_of_file,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_pixel_valid,
  output logic [7:0]                   out_red,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_blue,
  output logic [1:0]                   out_status,
  output logic                         out_last_in_run,
  output logic                         out_end_of_image,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bmpd_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import bmpd_pkg::*;

  // Parse state.
  phase_t            phase_r, phase_nxt;
  logic [31:0]       bc_r, bc_nxt;
  logic [31:0]       fs_r, fs_nxt;
  logic [31:0]       isz_r, isz_nxt;
  logic [DIM_W-1:0]  w_r, w_nxt, h_r, h_nxt;
  logic [4:0]        bpp_r, bpp_nxt;
  logic [8:0]        pc_r, pc_nxt;
  logic [DIM_W-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic [15:0]       pcol_r, pcol_nxt;
  logic [1:0]        k3_r, k3_nxt;
  logic              comp_bad_r, comp_bad_nxt;
  logic              dim_bad_r, dim_bad_nxt;
  logic              pal_bad_r, pal_bad_nxt;
  logic [1:0]        bfault_r, bfault_nxt;

  // Row geometry, derived from width and pixel depth long before use.
  logic [13:0]       db_r, db_nxt, rb_r, rb_nxt;

  // Byte hold stage.
  logic              busy_r, busy_nxt;
  logic              sof_r, sof_nxt;
  logic [2:0]        sub_r, sub_nxt;
  logic [7:0]        sh_r, sh_nxt;

  logic              mono_r;

  // Palette lookup stage.
  logic              b_valid_r;
  result_t           b_res_r;
  logic              b_mem_r, b_chk_r;

  logic              act, fin, iss, mem_rd, chk, acc, credit_ok, kill, pop;
  result_t           res, push_res, fifo_head;
  logic [PAL_AW-1:0] rd_addr;
  logic              wr_en;
  logic [PAL_AW-1:0] wr_addr;
  logic [23:0]       wr_data, ram_q;
  logic [FIFO_CW-1:0] fifo_cnt;
  logic              cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[CFG_AW-1:2] == REG_MONO_OUTPUT) ? {31'd0, mono_r} : 32'd0;

  // The byte stage may act only when a result slot is guaranteed downstream.
  assign credit_ok = (fifo_cnt + FIFO_CW'(b_valid_r)) < FIFO_CW'(FIFO_DEPTH);
  assign act       = busy_r && !kill && credit_ok;

  // Row geometry: bits per row rounded up to bytes, then to whole words.
  always_comb begin
    logic [16:0] wb;
    logic [13:0] db_p3;
    unique case (bpp_r)
      5'd1:    wb = 17'(w_r);
      5'd2:    wb = 17'(w_r) << 1;
      5'd4:    wb = 17'(w_r) << 2;
      5'd8:    wb = 17'(w_r) << 3;
      5'd24:   wb = (17'(w_r) << 4) + (17'(w_r) << 3);
      default: wb = '0;
    endcase
    db_nxt = 14'((wb + 17'd7) >> 3);
    db_p3  = db_nxt + 14'd3;
    rb_nxt = {db_p3[13:2], 2'b00};
  end

  // Next state of the parser and the byte stage.
  always_comb begin
    logic [31:0] fs_new;
    logic [13:0] col_inc, row_inc;
    logic        eoi;
    logic [7:0]  idx;
    logic [3:0]  per;
    logic [31:0] v;
    logic [15:0] v16;
    logic        count_byte;

    phase_nxt = phase_r;  bc_nxt = bc_r;  fs_nxt = fs_r;  isz_nxt = isz_r;
    w_nxt = w_r;  h_nxt = h_r;  bpp_nxt = bpp_r;  pc_nxt = pc_r;
    col_nxt = col_r;  row_nxt = row_r;  pcol_nxt = pcol_r;  k3_nxt = k3_r;
    comp_bad_nxt = comp_bad_r;  dim_bad_nxt = dim_bad_r;
    pal_bad_nxt = pal_bad_r;  bfault_nxt = bfault_r;
    sof_nxt = sof_r;  sub_nxt = sub_r;  sh_nxt = sh_r;
    iss = 1'b0;  res = '0;  mem_rd = 1'b0;  chk = 1'b0;  fin = 1'b0;
    wr_en = 1'b0;  wr_addr = '0;  wr_data = {sh_r, pcol_r};
    count_byte = 1'b0;
    fs_new  = {sh_r, fs_r[31:8]};
    v = '0;  v16 = '0;

    unique case (bpp_r)
      5'd1:    begin per = 4'd8; idx = {7'd0, sh_r[7]};   end
      5'd2:    begin per = 4'd4; idx = {6'd0, sh_r[7:6]}; end
      5'd4:    begin per = 4'd2; idx = {4'd0, sh_r[7:4]}; end
      default: begin per = 4'd1; idx = sh_r;              end
    endcase
    rd_addr = idx;
    col_inc = 14'(col_r) + 14'd1;
    row_inc = 14'(row_r) + 14'd1;
    eoi = (col_inc >= 14'(w_r)) && (row_inc >= 14'(h_r));

    if (act) begin
      fin = 1'b1;
      if (sub_r == 3'd0 && sof_r) begin
        phase_nxt = PH_SIG;  bc_nxt = '0;  fs_nxt = '0;  isz_nxt = '0;
        w_nxt = '0;  h_nxt = '0;  bpp_nxt = '0;  pc_nxt = '0;
        col_nxt = '0;  row_nxt = '0;  pcol_nxt = '0;  k3_nxt = '0;
        comp_bad_nxt = 1'b0;  dim_bad_nxt = 1'b0;  pal_bad_nxt = 1'b0;
        bfault_nxt = '0;
      end

      unique case (phase_nxt)
        PH_SIG: begin
          if (bc_nxt == 32'd0) begin
            if (sh_r != SIG_B) begin
              iss = 1'b1;  res.status = ST_CORRUPT;  phase_nxt = PH_ERR;
            end else begin
              bc_nxt = 32'd1;
            end
          end else if (sh_r != SIG_M) begin
            iss = 1'b1;  res.status = ST_CORRUPT;  phase_nxt = PH_ERR;
          end else begin
            phase_nxt = PH_FHDR;  bc_nxt = 32'd2;
          end
        end

        PH_FHDR: begin
          if (bc_nxt >= 32'd13) begin
            phase_nxt = PH_INFO;  bc_nxt = '0;  fs_nxt = '0;
          end else begin
            bc_nxt = bc_nxt + 32'd1;
          end
        end

        PH_INFO: begin
          fs_nxt = fs_new;
          if (bc_r == 32'd3) begin
            isz_nxt = fs_new;
          end else if (bc_r == 32'd7 || bc_r == 32'd11) begin
            v = fs_new;
            if (v[31] || v > 32'(MAX_DIM)) begin
              dim_bad_nxt = 1'b1;  v = '0;
            end
            if (bc_r == 32'd7) w_nxt = v[DIM_W-1:0];
            else               h_nxt = v[DIM_W-1:0];
          end else if (bc_r == 32'd15) begin
            v16 = fs_new[31:16];
            if (v16 == 16'd1 || v16 == 16'd2 || v16 == 16'd4 || v16 == 16'd8 ||
                v16 == 16'd24) begin
              bpp_nxt = v16[4:0];  bfault_nxt = '0;
            end else begin
              bpp_nxt = '0;
              bfault_nxt = (v16 == 16'd16 || v16 == 16'd32) ? ST_UNSUP : ST_CORRUPT;
            end
          end else if (bc_r == 32'd19) begin
            comp_bad_nxt = (fs_new != '0);
          end else if (bc_r == 32'd35) begin
            if (bfault_r == '0 && bpp_r < 5'd24) begin
              v = (fs_new != '0) ? fs_new : (32'd1 << bpp_r);
              if (v > 32'(PAL_DEPTH)) pal_bad_nxt = 1'b1;
              else                    pc_nxt = v[8:0];
            end
          end

          if (bc_r == 32'd3 && (fs_new < INFO_MIN || fs_new == INFO_BAD)) begin
            iss = 1'b1;  res.status = ST_UNSUP;  phase_nxt = PH_ERR;
          end else if (bc_r >= 32'd39 && (bc_r + 32'd1) == isz_r) begin
            if (comp_bad_nxt) begin
              iss = 1'b1;  res.status = ST_UNSUP;  phase_nxt = PH_ERR;
            end else if (bfault_nxt != '0) begin
              iss = 1'b1;  res.status = bfault_nxt;  phase_nxt = PH_ERR;
            end else if (dim_bad_nxt || pal_bad_nxt) begin
              iss = 1'b1;  res.status = ST_UNSUP;  phase_nxt = PH_ERR;
            end else if (bpp_nxt < 5'd24) begin
              phase_nxt = PH_PAL;  bc_nxt = '0;
            end else begin
              bc_nxt = '0;  col_nxt = '0;  row_nxt = '0;  pcol_nxt = '0;  k3_nxt = '0;
              phase_nxt = (w_nxt == '0 || h_nxt == '0) ? PH_DONE : PH_PIX;
            end
          end else begin
            bc_nxt = bc_r + 32'd1;
          end
        end

        PH_PAL: begin
          case (bc_r[1:0])
            2'd0: pcol_nxt = {8'd0, sh_r};
            2'd1: pcol_nxt[15:8] = sh_r;
            2'd2: begin
              if (bc_r[31:2] < 30'(PAL_DEPTH)) begin
                wr_en   = 1'b1;
                wr_addr = bc_r[PAL_AW+1:2];
              end
            end
            default: ;
          endcase
          bc_nxt = bc_r + 32'd1;
          if (bc_nxt >= {21'd0, pc_r, 2'b00}) begin
            bc_nxt = '0;  col_nxt = '0;  row_nxt = '0;  pcol_nxt = '0;  k3_nxt = '0;
            phase_nxt = (w_r == '0 || h_r == '0) ? PH_DONE : PH_PIX;
          end
        end

        PH_PIX: begin
          if (bc_r < 32'(db_r)) begin
            if (bpp_r == 5'd24) begin
              if (k3_r == 2'd0) begin
                pcol_nxt = {8'd0, sh_r};
              end else if (k3_r == 2'd1) begin
                pcol_nxt[15:8] = sh_r;
              end else begin
                iss = 1'b1;
                if (mono_r && !(sh_r == pcol_r[15:8] && pcol_r[15:8] == pcol_r[7:0])) begin
                  res.status = ST_NONGRAY;  phase_nxt = PH_ERR;
                end else begin
                  res.pixel_valid  = 1'b1;
                  res.red          = sh_r;
                  res.green        = pcol_r[15:8];
                  res.blue         = pcol_r[7:0];
                  res.end_of_image = eoi;
                  col_nxt = col_inc[DIM_W-1:0];
                  if (eoi) phase_nxt = PH_DONE;
                end
              end
              count_byte = 1'b1;
            end else if (4'(sub_r) < per && col_r < w_r) begin
              iss = 1'b1;
              if ({1'b0, idx} >= pc_r) begin
                res.status = ST_CORRUPT;  phase_nxt = PH_ERR;
              end else begin
                mem_rd = 1'b1;
                chk    = mono_r;
                res.pixel_valid  = 1'b1;
                res.end_of_image = eoi;
                col_nxt = col_inc[DIM_W-1:0];
                if (eoi) phase_nxt = PH_DONE;
                sub_nxt = sub_r + 3'd1;
                unique case (bpp_r)
                  5'd1:    sh_nxt = sh_r << 1;
                  5'd2:    sh_nxt = sh_r << 2;
                  5'd4:    sh_nxt = sh_r << 4;
                  default: sh_nxt = sh_r;
                endcase
                if ((4'(sub_r) + 4'd1) < per && col_inc < 14'(w_r) && !eoi) begin
                  fin = 1'b0;
                end else begin
                  count_byte = 1'b1;
                end
              end
            end else begin
              count_byte = 1'b1;
            end
          end else begin
            count_byte = 1'b1;
          end

          if (count_byte && phase_nxt == PH_PIX) begin
            bc_nxt = bc_r + 32'd1;
            k3_nxt = (k3_r == 2'd2) ? 2'd0 : k3_r + 2'd1;
            if (bc_nxt >= 32'(rb_r)) begin
              bc_nxt = '0;  k3_nxt = '0;  col_nxt = '0;
              row_nxt = row_inc[DIM_W-1:0];
            end
          end
        end

        PH_DONE, PH_ERR: ;
        default: ;
      endcase
      res.last_in_run = fin;
    end

    // A failed gray check on a palette pixel ends the file.
    if (kill) phase_nxt = PH_ERR;

    acc = in_valid && !(busy_r && !(act && fin));
    busy_nxt = acc ? 1'b1 : ((act && fin) ? 1'b0 : busy_r);
    if (acc) begin
      sh_nxt  = in_data_byte;
      sof_nxt = in_start_of_file;
      sub_nxt = '0;
    end
  end

  assign in_stall = busy_r && !(act && fin);

  // Palette memory.
  bmpd_pal_ram u_pal_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (mem_rd),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // Lookup stage: fills in palette colours and applies the mono check.
  always_comb begin
    push_res = b_res_r;
    kill     = 1'b0;
    if (b_mem_r) begin
      push_res.red   = ram_q[23:16];
      push_res.green = ram_q[15:8];
      push_res.blue  = ram_q[7:0];
    end
    if (b_valid_r && b_chk_r &&
        !(ram_q[23:16] == ram_q[15:8] && ram_q[15:8] == ram_q[7:0])) begin
      kill     = 1'b1;
      push_res = '0;
      push_res.status      = ST_NONGRAY;
      push_res.last_in_run = 1'b1;
    end
  end

  assign pop = out_valid && !out_stall;

  bmpd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (b_valid_r),
    .push_data (push_res),
    .pop       (pop),
    .head      (fifo_head),
    .not_empty (out_valid),
    .count     (fifo_cnt)
  );

  assign out_pixel_valid  = fifo_head.pixel_valid;
  assign out_red          = fifo_head.red;
  assign out_green        = fifo_head.green;
  assign out_blue         = fifo_head.blue;
  assign out_status       = fifo_head.status;
  assign out_last_in_run  = fifo_head.last_in_run;
  assign out_end_of_image = fifo_head.end_of_image;

  // Payload registers.
  always_ff @(posedge clk) begin
    sof_r   <= sof_nxt;
    sh_r    <= sh_nxt;
    b_res_r <= res;
    b_mem_r <= mem_rd;
    b_chk_r <= chk;
    db_r    <= db_nxt;
    rb_r    <= rb_nxt;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIG;  bc_r <= '0;  fs_r <= '0;  isz_r <= '0;
      w_r <= '0;  h_r <= '0;  bpp_r <= '0;  pc_r <= '0;
      col_r <= '0;  row_r <= '0;  pcol_r <= '0;  k3_r <= '0;
      comp_bad_r <= 1'b0;  dim_bad_r <= 1'b0;  pal_bad_r <= 1'b0;
      bfault_r <= '0;
      busy_r <= 1'b0;  sub_r <= '0;
      b_valid_r <= 1'b0;
      mono_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;  bc_r <= bc_nxt;  fs_r <= fs_nxt;  isz_r <= isz_nxt;
      w_r <= w_nxt;  h_r <= h_nxt;  bpp_r <= bpp_nxt;  pc_r <= pc_nxt;
      col_r <= col_nxt;  row_r <= row_nxt;  pcol_r <= pcol_nxt;  k3_r <= k3_nxt;
      comp_bad_r <= comp_bad_nxt;  dim_bad_r <= dim_bad_nxt;
      pal_bad_r <= pal_bad_nxt;  bfault_r <= bfault_nxt;
      busy_r <= busy_nxt;  sub_r <= sub_nxt;
      b_valid_r <= iss;
      if (cfg_wr && paddr[CFG_AW-1:2] == REG_MONO_OUTPUT) begin
        mono_r <= pwdata[0];
      end
    end
  end

  // The queue always has room for a result leaving the lookup stage.
  `BMPD_ASSERT_SAME(a_fifo_room, b_valid_r, (fifo_cnt < FIFO_CW'(FIFO_DEPTH)) || pop)
  // A gray check failure can only come from a checked palette lookup.
  `BMPD_ASSERT_SAME(a_kill_src, kill, b_chk_r && mono_r)
  // After a gray check failure the parser sits in the error phase.
  `BMPD_ASSERT_NEXT(a_kill_err, kill, phase_r == PH_ERR)
  // Palette lookups are only issued while decoding pixels.
  `BMPD_ASSERT_NEXT(a_lookup_phase, mem_rd, b_mem_r && b_valid_r)

endmodule
